// ----- rtl/core/fxa_pkg.sv -----
// fxa_pkg: opcodes, status codes and default sizes of the fixed-point alu
// used by the core, its checker and the testbench; no dependencies
`default_nettype none

package fxa_pkg;

    localparam int DEF_WORD_BITS     = 32;
    localparam int DEF_FRACTION_BITS = 8;

    localparam int FIELD_BITS  = 32;
    localparam int IN_DATA_W   = 64;
    localparam int IN_USER_W   = 4;
    localparam int OUT_DATA_W  = 40;

    localparam logic [3:0] OP_ADD      = 4'd0;
    localparam logic [3:0] OP_SUB      = 4'd1;
    localparam logic [3:0] OP_MUL      = 4'd2;
    localparam logic [3:0] OP_DIV      = 4'd3;
    localparam logic [3:0] OP_GT       = 4'd4;
    localparam logic [3:0] OP_LT       = 4'd5;
    localparam logic [3:0] OP_GE       = 4'd6;
    localparam logic [3:0] OP_LE       = 4'd7;
    localparam logic [3:0] OP_EQ       = 4'd8;
    localparam logic [3:0] OP_NE       = 4'd9;
    localparam logic [3:0] OP_INC      = 4'd10;
    localparam logic [3:0] OP_DEC      = 4'd11;
    localparam logic [3:0] OP_MIN      = 4'd12;
    localparam logic [3:0] OP_MAX      = 4'd13;
    localparam logic [3:0] OP_TO_INT   = 4'd14;
    localparam logic [3:0] OP_FROM_INT = 4'd15;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OVF  = 2'd1;
    localparam logic [1:0] ST_DIVZ = 2'd2;

endpackage

`default_nettype wire

// ----- rtl/core/fxa_div_step.sv -----
// fxa_div_step: one restoring division step, one quotient bit
// depends on nothing; instantiated once per divider stage by the core
`default_nettype none

module fxa_div_step #(
    parameter int WORD_BITS = 32,
    parameter int QUOT_BITS = 40
) (
    input  wire logic [WORD_BITS-1:0] i_rem,
    input  wire logic                 i_bit,
    input  wire logic [QUOT_BITS-1:0] i_quot,
    input  wire logic [WORD_BITS-1:0] i_div,
    output logic      [WORD_BITS-1:0] o_rem,
    output logic      [QUOT_BITS-1:0] o_quot
);

    logic [WORD_BITS:0] shifted;
    logic               take;

    always_comb begin
        shifted = {i_rem, i_bit};
        take    = shifted >= {1'b0, i_div};
        o_rem   = take ? WORD_BITS'(shifted - {1'b0, i_div}) : shifted[WORD_BITS-1:0];
        o_quot  = {i_quot[QUOT_BITS-2:0], take};
    end

endmodule

`default_nettype wire

// ----- rtl/core/fixed_point_alu_core.sv -----
// fixed_point_alu_core: pipelined signed fixed-point alu, top level
// depends on fxa_pkg and fxa_div_step
`default_nettype none

// Takes one request per clock while the output is not held by back-pressure,
// and returns one result per request, in order. Every opcode passes the same
// stages in order: decode, multiply, multiply rounding, one restoring divider
// stage per quotient bit, then divide rounding into the output register.
// The divider stages set the depth. Each stage holds its request until the
// next one is free, so empty stages fill while a result waits on the output.
// Multiply and divide round half away from zero; overflow saturates.
module fixed_point_alu_core #(
    parameter int WORD_BITS     = fxa_pkg::DEF_WORD_BITS,
    parameter int FRACTION_BITS = fxa_pkg::DEF_FRACTION_BITS
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // operand_a [31:0], operand_b [63:32]
    input  wire logic [fxa_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // opcode [3:0]
    input  wire logic [fxa_pkg::IN_USER_W-1:0]  s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // result_word [31:0], compare_true [32], status [34:33], zero [39:35]
    output logic      [fxa_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import fxa_pkg::*;

    localparam int W  = WORD_BITS;
    localparam int F  = FRACTION_BITS;
    localparam int DS = W + F;
    localparam int QW = 2 * W;
    localparam int P  = 3 + DS;
    localparam int L  = P + 1;

    localparam logic [W-1:0]  WMAX   = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]  WMIN   = {1'b1, {(W-1){1'b0}}};
    localparam logic [QW-1:0] LIM_P  = QW'(WMAX);
    localparam logic [QW-1:0] LIM_N  = QW'(WMIN);
    localparam logic [QW-1:0] HALF   = (QW'(1) << F) >> 1;

    function automatic logic [W+1:0] sat_mag(input logic [QW-1:0] m, input logic neg);
        logic          ovf;
        logic [W-1:0]  v;
        begin
            if (neg) begin
                ovf = m > LIM_N;
                v   = ovf ? WMIN : W'(~m[W-1:0] + W'(1));
            end else begin
                ovf = m > LIM_P;
                v   = ovf ? WMAX : m[W-1:0];
            end
            return {(ovf ? ST_OVF : ST_OK), v};
        end
    endfunction

    logic [L:1] r_vld;
    logic [L:1] en;

    logic [3:0]    r_op    [1:P];
    logic          r_neg   [1:P];
    logic [W-1:0]  r_res   [1:P];
    logic          r_cmp   [1:P];
    logic [1:0]    r_st    [1:P];
    logic          r_dlive [1:P];

    logic [W-1:0]  r1_ma, r1_mb, r2_ma, r2_mb;
    logic [QW-1:0] r2_prod;

    logic [W-1:0]  r_rem [0:DS];
    logic [DS-1:0] r_q   [0:DS];
    logic [W-1:0]  r_d   [0:DS];
    logic [DS-1:0] r_n   [0:DS-1];

    logic [W-1:0]  r_out_res;
    logic          r_out_cmp;
    logic [1:0]    r_out_st;

    // handshake chain
    assign en[L] = !r_vld[L] || m_axis_tready;
    for (genvar k = 1; k < L; k++) begin : g_en
        assign en[k] = !r_vld[k] || en[k+1];
    end
    assign s_axis_tready = en[1];
    assign m_axis_tvalid = r_vld[L];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[1]) begin
                r_vld[1] <= s_axis_tvalid;
            end
            for (int k = 2; k <= L; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // decode stage
    logic signed [W-1:0]   a, b;
    logic [3:0]            op;
    logic [W-1:0]          y;
    logic                  cin;
    logic [W:0]            s;
    logic signed [W+F-1:0] ax, fw;
    logic [W-1:0]          n_res;
    logic                  n_cmp;
    logic [1:0]            n_st;

    always_comb begin
        a   = s_axis_tdata[W-1:0];
        b   = s_axis_tdata[FIELD_BITS+W-1:FIELD_BITS];
        op  = s_axis_tuser;
        y   = b;
        cin = 1'b0;
        unique case (op)
            OP_SUB:  begin y = ~b;       cin = 1'b1; end
            OP_INC:  begin y = '0;       cin = 1'b1; end
            OP_DEC:  begin y = '1;       cin = 1'b0; end
            default: begin y = b;        cin = 1'b0; end
        endcase
        s     = {a[W-1], a} + {y[W-1], y} + (W+1)'(cin);
        ax    = (W+F)'(a);
        fw    = ax <<< F;
        n_res = '0;
        n_cmp = 1'b0;
        n_st  = ST_OK;
        unique case (op)
            OP_ADD, OP_SUB, OP_INC, OP_DEC: begin
                if (s[W] != s[W-1]) begin
                    n_res = s[W] ? WMIN : WMAX;
                    n_st  = ST_OVF;
                end else begin
                    n_res = s[W-1:0];
                end
            end
            OP_MUL: n_res = '0;
            OP_DIV: begin
                if (b == '0) begin
                    n_st  = ST_DIVZ;
                    n_res = a[W-1] ? WMIN : ((a == '0) ? '0 : WMAX);
                end
            end
            OP_GT: n_cmp = a > b;
            OP_LT: n_cmp = a < b;
            OP_GE: n_cmp = a >= b;
            OP_LE: n_cmp = a <= b;
            OP_EQ: n_cmp = a == b;
            OP_NE: n_cmp = a != b;
            OP_MIN: n_res = (a > b) ? b : a;
            OP_MAX: n_res = (a < b) ? b : a;
            OP_TO_INT: n_res = W'(a >>> F);
            OP_FROM_INT: begin
                if (fw[W+F-1:W-1] != {(F+1){fw[W-1]}}) begin
                    n_res = a[W-1] ? WMIN : WMAX;
                    n_st  = ST_OVF;
                end else begin
                    n_res = fw[W-1:0];
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_op[1]    <= op;
            r_neg[1]   <= a[W-1] ^ b[W-1];
            r_res[1]   <= n_res;
            r_cmp[1]   <= n_cmp;
            r_st[1]    <= n_st;
            r_dlive[1] <= (op == OP_DIV) && (b != '0);
            r1_ma      <= a[W-1] ? W'(-a) : a;
            r1_mb      <= b[W-1] ? W'(-b) : b;
        end
    end

    // common fields ride along
    for (genvar k = 2; k <= P; k++) begin : g_ride
        if (k == 3) begin : g_mul
            logic [W+1:0] n_mul;
            assign n_mul = sat_mag((r2_prod + HALF) >> F, r_neg[2]);
            always_ff @(posedge i_clk) begin
                if (en[k]) begin
                    r_op[k]    <= r_op[k-1];
                    r_neg[k]   <= r_neg[k-1];
                    r_cmp[k]   <= r_cmp[k-1];
                    r_dlive[k] <= r_dlive[k-1];
                    if (r_op[k-1] == OP_MUL) begin
                        r_res[k] <= n_mul[W-1:0];
                        r_st[k]  <= n_mul[W+1:W];
                    end else begin
                        r_res[k] <= r_res[k-1];
                        r_st[k]  <= r_st[k-1];
                    end
                end
            end
        end else begin : g_pass
            always_ff @(posedge i_clk) begin
                if (en[k]) begin
                    r_op[k]    <= r_op[k-1];
                    r_neg[k]   <= r_neg[k-1];
                    r_res[k]   <= r_res[k-1];
                    r_cmp[k]   <= r_cmp[k-1];
                    r_st[k]    <= r_st[k-1];
                    r_dlive[k] <= r_dlive[k-1];
                end
            end
        end
    end

    // multiply stage
    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r2_ma   <= r1_ma;
            r2_mb   <= r1_mb;
            r2_prod <= QW'(r1_ma) * QW'(r1_mb);
        end
    end

    // divider setup
    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r_rem[0] <= '0;
            r_q[0]   <= '0;
            r_d[0]   <= r2_mb;
            r_n[0]   <= DS'(r2_ma) << F;
        end
    end

    // one quotient bit per stage
    for (genvar j = 1; j <= DS; j++) begin : g_div
        logic [W-1:0]  w_rem;
        logic [DS-1:0] w_q;

        fxa_div_step #(
            .WORD_BITS (W),
            .QUOT_BITS (DS)
        ) u_step (
            .i_rem  (r_rem[j-1]),
            .i_bit  (r_n[j-1][DS-1]),
            .i_quot (r_q[j-1]),
            .i_div  (r_d[j-1]),
            .o_rem  (w_rem),
            .o_quot (w_q)
        );

        always_ff @(posedge i_clk) begin
            if (en[3+j]) begin
                r_rem[j] <= w_rem;
                r_q[j]   <= w_q;
                r_d[j]   <= r_d[j-1];
            end
        end

        if (j < DS) begin : g_shift
            always_ff @(posedge i_clk) begin
                if (en[3+j]) begin
                    r_n[j] <= r_n[j-1] << 1;
                end
            end
        end
    end

    // divide rounding and output register
    logic          round_up;
    logic [QW-1:0] div_mag;
    logic [W+1:0]  n_div;

    always_comb begin
        round_up = {r_rem[DS], 1'b0} >= {1'b0, r_d[DS]};
        div_mag  = QW'(r_q[DS]) + QW'(round_up);
        n_div    = sat_mag(div_mag, r_neg[P]);
    end

    always_ff @(posedge i_clk) begin
        if (en[L]) begin
            r_out_cmp <= r_cmp[P];
            if (r_dlive[P]) begin
                r_out_res <= n_div[W-1:0];
                r_out_st  <= n_div[W+1:W];
            end else begin
                r_out_res <= r_res[P];
                r_out_st  <= r_st[P];
            end
        end
    end

    assign m_axis_tdata = {(OUT_DATA_W-FIELD_BITS-3)'(0), r_out_st, r_out_cmp,
                           FIELD_BITS'(signed'(r_out_res))};

endmodule

`default_nettype wire

// ----- rtl/core/fxa_checker.sv -----
// fxa_checker: port-level assertions for fixed_point_alu_core, bound to it
// depends on fxa_pkg
`default_nettype none

module fxa_checker #(
    parameter int WORD_BITS = fxa_pkg::DEF_WORD_BITS
) (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           s_axis_tvalid,
    input wire logic                           s_axis_tready,
    input wire logic [fxa_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input wire logic [fxa_pkg::IN_USER_W-1:0]  s_axis_tuser,
    input wire logic                           m_axis_tvalid,
    input wire logic                           m_axis_tready,
    input wire logic [fxa_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import fxa_pkg::*;

    localparam logic [31:0] SAT_HI = 32'((64'd1 << (WORD_BITS - 1)) - 64'd1);
    localparam logic [31:0] SAT_LO = ~SAT_HI;

    logic [31:0] res;
    logic        cmp;
    logic [1:0]  st;

    assign res = m_axis_tdata[31:0];
    assign cmp = m_axis_tdata[32];
    assign st  = m_axis_tdata[34:33];

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (st == ST_OK) || (st == ST_OVF) || (st == ST_DIVZ))
        else $error("bad status code");

    a_cmp_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && cmp |-> (res == 32'd0) && (st == ST_OK))
        else $error("compare result with nonzero word or status");

    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (st == ST_OVF) |-> (res == SAT_HI) || (res == SAT_LO))
        else $error("overflow without saturated word");

    a_word_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (res[31:WORD_BITS-1] == '0) || (res[31:WORD_BITS-1] == '1))
        else $error("result not sign extended");

endmodule

bind fixed_point_alu_core fxa_checker #(
    .WORD_BITS (WORD_BITS)
) u_fxa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ----- tb/sv/testbench.sv -----
// testbench: self-checking regression of the pipelined fixed-point alu core
// depends on fxa_pkg and fixed_point_alu_core; predicts each result in sv
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import fxa_pkg::*;

    localparam int FB = DEF_FRACTION_BITS;
    localparam longint WMAX = 64'sd2147483647;
    localparam longint WMIN = -64'sd2147483648;
    localparam int LATENCY = DEF_WORD_BITS + DEF_FRACTION_BITS + 4;

    typedef struct packed {
        logic [1:0]  status;
        logic        compare_true;
        logic [31:0] result_word;
    } alu_result_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic [3:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;

    alu_result_t expected_results[$];
    int  mismatch_count = 0;
    int  unexpected_count = 0;
    int  burst_left = 0;
    bit  hold_off_request = 1'b0;
    bit  random_stall = 1'b1;

    fixed_point_alu_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("Regression FAIL");
        $finish;
    end

    function automatic longint saturate(input longint v, inout logic [1:0] st);
        if (v > WMAX) begin
            st = ST_OVF;
            return WMAX;
        end
        if (v < WMIN) begin
            st = ST_OVF;
            return WMIN;
        end
        return v;
    endfunction

    function automatic alu_result_t compute_alu(input logic [3:0] op,
                                                input logic signed [31:0] a32,
                                                input logic signed [31:0] b32);
        longint a, b, r;
        logic [63:0] ma, mb, p, q, n;
        logic [1:0] st;
        logic cmp;
        alu_result_t res;
        a = a32;
        b = b32;
        r = 0;
        st = ST_OK;
        cmp = 1'b0;
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        case (op)
            OP_ADD: r = saturate(a + b, st);
            OP_SUB: r = saturate(a - b, st);
            OP_MUL: begin
                p = ma * mb;
                q = (p + (64'd1 << (FB - 1))) >> FB;
                r = saturate(((a < 0) != (b < 0)) ? -longint'(q) : longint'(q), st);
            end
            OP_DIV: begin
                if (b == 0) begin
                    st = ST_DIVZ;
                    r = (a > 0) ? WMAX : ((a < 0) ? WMIN : 0);
                end else begin
                    n = ma << FB;
                    q = (2 * n + mb) / (2 * mb);
                    r = saturate(((a < 0) != (b < 0)) ? -longint'(q) : longint'(q), st);
                end
            end
            OP_GT: cmp = a > b;
            OP_LT: cmp = a < b;
            OP_GE: cmp = a >= b;
            OP_LE: cmp = a <= b;
            OP_EQ: cmp = a == b;
            OP_NE: cmp = a != b;
            OP_INC: r = saturate(a + 1, st);
            OP_DEC: r = saturate(a - 1, st);
            OP_MIN: r = (a > b) ? b : a;
            OP_MAX: r = (a < b) ? b : a;
            OP_TO_INT: r = a >>> FB;
            default: r = saturate(a * (64'sd1 <<< FB), st);
        endcase
        res.result_word = r[31:0];
        res.compare_true = cmp;
        res.status = st;
        return res;
    endfunction

    task automatic send_request(input logic [3:0] op, input logic [31:0] a,
                                input logic [31:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? int'($urandom_range(1, 6)) : 0;
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {b, a};
        do @(posedge i_clk); while (!s_axis_tready);
        expected_results.push_back(compute_alu(op, a, b));
        @(negedge i_clk);
    endtask

    task automatic drain_results;
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (expected_results.size() != 0);
    endtask

    function automatic logic [31:0] random_word;
        case ($urandom_range(0, 7))
            0: return 32'h7fffffff - $urandom_range(0, 2);
            1: return 32'h80000000 + $urandom_range(0, 2);
            2: return $urandom_range(0, 600) - 300;
            3: return ($urandom_range(0, 65535) - 32768) << FB;
            4: return $urandom_range(0, 1) ? 32'h0 : 32'hffffffff;
            5: return $signed($urandom()) >>> $urandom_range(8, 24);
            default: return $urandom();
        endcase
    endfunction

    task automatic test_directed;
        logic [3:0] op;
        send_request(OP_ADD, 32'h7fffffff, 32'h1);
        send_request(OP_SUB, 32'h80000000, 32'h1);
        send_request(OP_ADD, 32'h80000000, 32'h80000000);
        send_request(OP_MUL, 32'h80000000, 32'h80000000);
        send_request(OP_MUL, 32'h00000180, 32'hffffff01);
        send_request(OP_MUL, 32'h00000080, 32'h00000001);
        send_request(OP_DIV, 32'h00000100, 32'h0);
        send_request(OP_DIV, 32'hffffff00, 32'h0);
        send_request(OP_DIV, 32'h0, 32'h0);
        send_request(OP_DIV, 32'h7fffffff, 32'h1);
        send_request(OP_DIV, 32'h80000000, 32'hffffffff);
        send_request(OP_DIV, 32'h00000001, 32'h00000200);
        send_request(OP_MIN, 32'h5, 32'h5);
        send_request(OP_MAX, 32'h5, 32'h5);
        send_request(OP_INC, 32'h7fffffff, 32'h0);
        send_request(OP_DEC, 32'h80000000, 32'h0);
        send_request(OP_TO_INT, 32'hffffff01, 32'h0);
        send_request(OP_FROM_INT, 32'h00800000, 32'h0);
        send_request(OP_FROM_INT, 32'hff7fffff, 32'h0);
        for (int i = int'(OP_GT); i <= int'(OP_NE); i++) begin
            op = i[3:0];
            send_request(op, 32'h80000000, 32'h7fffffff);
        end
        drain_results();
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++)
            send_request(4'($urandom_range(0, 15)), random_word(), random_word());
    endtask

    task automatic test_backpressure;
        hold_off_request = 1'b1;
        test_random(120);
        drain_results();
    endtask

    task automatic test_no_stall;
        random_stall = 1'b0;
        test_random(200);
        drain_results();
        random_stall = 1'b1;
    endtask

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_random(1100);
        drain_results();
        test_backpressure();
        test_no_stall();
        repeat (LATENCY + 10) @(negedge i_clk);
        if (mismatch_count == 0 && unexpected_count == 0 && expected_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_off_request) begin
                m_axis_tready <= 1'b0;
                repeat (300) @(negedge i_clk);
                hold_off_request = 1'b0;
            end else if (random_stall) begin
                m_axis_tready <= ($urandom_range(0, 3) != 0);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        alu_result_t got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[34:0];
            if (expected_results.size() == 0) begin
                unexpected_count++;
                $display("unexpected result %h", m_axis_tdata);
            end else begin
                want = expected_results.pop_front();
                if (got !== want || m_axis_tdata[39:35] !== 5'd0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected word %h cmp %b st %0d, got %h %b %0d",
                                 want.result_word, want.compare_true, want.status,
                                 got.result_word, got.compare_true, got.status);
                end
            end
        end
    end

endmodule

`default_nettype wire
